[rtl/core/mtxinv_pkg.sv]
// Shared constants for the 3x3 fixed-point matrix inverse.
// Holds the cofactor index tables; no dependencies.
package mtxinv_pkg;

   localparam int unsigned N_ENTRIES = 9;
   localparam int unsigned N_DETERM  = 3;

   typedef logic [3:0] idx_type;

   // Entry order a b c / d e f / g h k maps to indexes 0 .. 8.
   // Cofactor i is m[POS_A[i]]*m[POS_B[i]] - m[NEG_A[i]]*m[NEG_B[i]],
   // already transposed so cofactor i lands on inverse entry i.
   localparam idx_type POS_A [N_ENTRIES] = '{4, 2, 1, 5, 0, 2, 3, 6, 0};
   localparam idx_type POS_B [N_ENTRIES] = '{8, 7, 5, 6, 8, 3, 7, 1, 4};
   localparam idx_type NEG_A [N_ENTRIES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam idx_type NEG_B [N_ENTRIES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   // Cofactors that pair with the first row in the determinant expansion.
   localparam idx_type DET_COF [N_DETERM] = '{0, 3, 6};

endpackage

[rtl/core/mtxinv_if.sv]
// Valid/ready channel interfaces for the matrix inverse: request and response.
// Standalone; widths follow the ENTRY_WIDTH parameter of each instance.
interface mtxinv_req_if #(parameter int ENTRY_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [ENTRY_WIDTH-1:0] m00, m01, m02;
   logic signed [ENTRY_WIDTH-1:0] m10, m11, m12;
   logic signed [ENTRY_WIDTH-1:0] m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

interface mtxinv_rsp_if #(parameter int ENTRY_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [ENTRY_WIDTH-1:0] inv00, inv01, inv02;
   logic signed [ENTRY_WIDTH-1:0] inv10, inv11, inv12;
   logic signed [ENTRY_WIDTH-1:0] inv20, inv21, inv22;
   logic                          singular;
   logic                          overflow;

   modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                   inv20, inv21, inv22, singular, overflow, input ready);
   modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                   inv20, inv21, inv22, singular, overflow, output ready);
endinterface

[rtl/core/matrix_inverse_3x3.sv]
// 3x3 matrix inverse by the adjugate, signed fixed point (Q16.16 by default).
// Depends on mtxinv_pkg and the channel interfaces in mtxinv_if.sv.
//
// One matrix enters per clock while the output register is free or being
// emptied. Cofactors and determinant are exact; each of the nine entries then
// runs through its own restoring divider laid out as ENTRY_WIDTH pipeline
// stages, one quotient bit per stage, so the divider depth sets the latency
// while throughput stays one transaction per cycle unless the response stalls.
// Quotients truncate toward zero and saturate with the overflow flag; a zero
// determinant gives all-zero entries with singular set. When the response is
// not taken the whole pipeline holds.
module matrix_inverse_3x3 #(
   parameter int FRAC_BITS   = 16,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   mtxinv_req_if.sink   req,
   mtxinv_rsp_if.source rsp
);
   import mtxinv_pkg::*;

   localparam int W    = ENTRY_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int PW   = 2 * W;            // entry product
   localparam int CW   = 2 * W + 1;        // cofactor
   localparam int QW   = 2 * W + 1;        // partial determinant product
   localparam int TW   = 3 * W + 1;        // determinant term
   localparam int DW   = 3 * W + 3;        // determinant, divisor
   localparam int NW   = CW + 2 * F;       // scaled dividend
   localparam int TOPW = NW - W;
   localparam int XW   = (TOPW > DW) ? TOPW : DW;
   localparam int NV   = W + 8;            // stages carrying a valid bit

   localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic [DW-1:0] rem;
      logic [W-1:0]  nlo;
      logic [W-1:0]  quo;
      logic          neg;
      logic          sat;
   } lane_type;

   typedef struct packed {
      lane_type [N_ENTRIES-1:0] lane;
      logic [DW-1:0]            den;
      logic                     sing;
   } div_type;

   logic            adv;
   logic [NV-1:0]   vld_ff;
   logic            rsp_valid_ff;

   // input capture
   logic signed [W-1:0]  m_in   [N_ENTRIES];
   logic signed [W-1:0]  m_ff   [N_ENTRIES];
   // entry products
   logic signed [PW-1:0] pp_in  [N_ENTRIES];
   logic signed [PW-1:0] pn_in  [N_ENTRIES];
   logic signed [PW-1:0] pp_ff  [N_ENTRIES];
   logic signed [PW-1:0] pn_ff  [N_ENTRIES];
   logic signed [W-1:0]  r1_ff  [N_DETERM];
   // cofactors
   logic signed [CW-1:0] cof_in [N_ENTRIES];
   logic signed [CW-1:0] cof2_ff[N_ENTRIES];
   logic signed [W-1:0]  r2_ff  [N_DETERM];
   // determinant products
   logic signed [QW-1:0] plo_in [N_DETERM];
   logic signed [QW-1:0] phi_in [N_DETERM];
   logic signed [QW-1:0] plo_ff [N_DETERM];
   logic signed [QW-1:0] phi_ff [N_DETERM];
   logic signed [CW-1:0] cof3_ff[N_ENTRIES];
   // determinant terms
   logic signed [TW-1:0] term_in[N_DETERM];
   logic signed [TW-1:0] term_ff[N_DETERM];
   logic signed [CW-1:0] cof4_ff[N_ENTRIES];
   // determinant
   logic signed [DW-1:0] det_in;
   logic signed [DW-1:0] det_ff;
   logic signed [CW-1:0] cof5_ff[N_ENTRIES];
   // magnitudes
   logic [CW-1:0]        acof_in[N_ENTRIES];
   logic [CW-1:0]        acof_ff[N_ENTRIES];
   logic [N_ENTRIES-1:0] neg_in;
   logic [N_ENTRIES-1:0] neg_ff;
   logic [DW-1:0]        den_in;
   logic [DW-1:0]        den_ff;
   logic                 sing_in;
   logic                 sing_ff;
   // divider stages
   div_type              div_in [W+1];
   div_type              div_ff [W+1];
   // result
   logic [W-1:0]         inv_in [N_ENTRIES];
   logic [W-1:0]         inv_ff [N_ENTRIES];
   logic                 ovf_in;
   logic                 ovf_ff;
   logic                 sing_out_ff;

   // advance everything while the output register is free or being emptied
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   assign m_in[0] = req.m00;
   assign m_in[1] = req.m01;
   assign m_in[2] = req.m02;
   assign m_in[3] = req.m10;
   assign m_in[4] = req.m11;
   assign m_in[5] = req.m12;
   assign m_in[6] = req.m20;
   assign m_in[7] = req.m21;
   assign m_in[8] = req.m22;

   always_comb begin
      for (int i = 0; i < N_ENTRIES; i++) begin
         pp_in[i]  = m_ff[POS_A[i]] * m_ff[POS_B[i]];
         pn_in[i]  = m_ff[NEG_A[i]] * m_ff[NEG_B[i]];
         cof_in[i] = CW'(pp_ff[i]) - CW'(pn_ff[i]);
      end
   end

   always_comb begin
      for (int j = 0; j < N_DETERM; j++) begin
         plo_in[j]  = r2_ff[j] * $signed({1'b0, cof2_ff[DET_COF[j]][W-1:0]});
         phi_in[j]  = r2_ff[j] * $signed(cof2_ff[DET_COF[j]][CW-1:W]);
         term_in[j] = (TW'(phi_ff[j]) <<< W) + TW'(plo_ff[j]);
      end
      det_in = DW'(term_ff[0]) + DW'(term_ff[1]) + DW'(term_ff[2]);
   end

   always_comb begin
      den_in  = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
      sing_in = (det_ff == '0);
      for (int i = 0; i < N_ENTRIES; i++) begin
         acof_in[i] = cof5_ff[i][CW-1] ? CW'(-cof5_ff[i]) : CW'(cof5_ff[i]);
         neg_in[i]  = cof5_ff[i][CW-1] ^ det_ff[DW-1];
      end
   end

   // seed the dividers: a top slice at or above the divisor means the
   // quotient needs more than ENTRY_WIDTH bits
   always_comb begin : div_seed
      logic [NW-1:0]   num;
      logic [TOPW-1:0] top;
      div_in[0].den  = den_ff;
      div_in[0].sing = sing_ff;
      for (int i = 0; i < N_ENTRIES; i++) begin
         num = NW'(acof_ff[i]) << (2 * F);
         top = num[NW-1:W];
         div_in[0].lane[i].sat = (XW'(top) >= XW'(den_ff));
         div_in[0].lane[i].rem = DW'(XW'(top));
         div_in[0].lane[i].nlo = num[W-1:0];
         div_in[0].lane[i].quo = '0;
         div_in[0].lane[i].neg = neg_ff[i];
      end
   end

   for (genvar s = 0; s < W; s++) begin : g_div
      always_comb begin : div_step
         logic [DW:0] trial;
         div_in[s+1] = div_ff[s];
         for (int i = 0; i < N_ENTRIES; i++) begin
            trial = {div_ff[s].lane[i].rem, div_ff[s].lane[i].nlo[W-1]};
            div_in[s+1].lane[i].nlo = div_ff[s].lane[i].nlo << 1;
            if (trial >= {1'b0, div_ff[s].den}) begin
               div_in[s+1].lane[i].rem = DW'(trial - {1'b0, div_ff[s].den});
               div_in[s+1].lane[i].quo = {div_ff[s].lane[i].quo[W-2:0], 1'b1};
            end else begin
               div_in[s+1].lane[i].rem = DW'(trial);
               div_in[s+1].lane[i].quo = {div_ff[s].lane[i].quo[W-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin : result
      logic [W-1:0] q;
      logic         neg;
      logic         sat;
      ovf_in = 1'b0;
      for (int i = 0; i < N_ENTRIES; i++) begin
         q   = div_ff[W].lane[i].quo;
         neg = div_ff[W].lane[i].neg;
         sat = div_ff[W].lane[i].sat ||
               (neg ? (q[W-1] && (|q[W-2:0])) : q[W-1]);
         if (div_ff[W].sing) begin
            inv_in[i] = '0;
         end else if (sat) begin
            inv_in[i] = neg ? MIN_VAL : MAX_VAL;
            ovf_in    = 1'b1;
         end else begin
            inv_in[i] = neg ? (~q + W'(1)) : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[NV-2:0], req.valid};
         rsp_valid_ff <= vld_ff[NV-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < N_ENTRIES; i++) begin
            m_ff[i]    <= m_in[i];
            pp_ff[i]   <= pp_in[i];
            pn_ff[i]   <= pn_in[i];
            cof2_ff[i] <= cof_in[i];
            cof3_ff[i] <= cof2_ff[i];
            cof4_ff[i] <= cof3_ff[i];
            cof5_ff[i] <= cof4_ff[i];
            acof_ff[i] <= acof_in[i];
            inv_ff[i]  <= inv_in[i];
         end
         for (int j = 0; j < N_DETERM; j++) begin
            r1_ff[j]   <= m_ff[j];
            r2_ff[j]   <= r1_ff[j];
            plo_ff[j]  <= plo_in[j];
            phi_ff[j]  <= phi_in[j];
            term_ff[j] <= term_in[j];
         end
         det_ff      <= det_in;
         neg_ff      <= neg_in;
         den_ff      <= den_in;
         sing_ff     <= sing_in;
         for (int s = 0; s <= W; s++) begin
            div_ff[s] <= div_in[s];
         end
         ovf_ff      <= ovf_in;
         sing_out_ff <= div_ff[W].sing;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.inv00    = inv_ff[0];
   assign rsp.inv01    = inv_ff[1];
   assign rsp.inv02    = inv_ff[2];
   assign rsp.inv10    = inv_ff[3];
   assign rsp.inv11    = inv_ff[4];
   assign rsp.inv12    = inv_ff[5];
   assign rsp.inv20    = inv_ff[6];
   assign rsp.inv21    = inv_ff[7];
   assign rsp.inv22    = inv_ff[8];
   assign rsp.singular = sing_out_ff;
   assign rsp.overflow = ovf_ff;

endmodule
